>>> design/arpc_pkg.sv
// Shared types and constants for the ARP cache and responder.
package arpc_pkg;

  // Cache geometry
  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  // Configuration port
  localparam int ADDR_W = 4;
  localparam int DATA_W = 64;

  typedef enum logic {
    REG_LOCAL_MAC = 1'b0,
    REG_LOCAL_IP  = 1'b1
  } reg_idx_t;

  // ARP codes
  localparam logic [15:0] ARP_OP_REQUEST = 16'd1;
  localparam logic [1:0]  OP_NONE        = 2'd0;
  localparam logic [1:0]  OP_REQUEST     = 2'd1;
  localparam logic [1:0]  OP_REPLY       = 2'd2;
  localparam logic [47:0] BCAST_MAC      = 48'hFFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_UPDATE = 2'd2,
    ACT_FULL   = 2'd3
  } action_t;

  // Lookup key held per cache entry
  typedef struct packed {
    logic [15:0] proto;
    logic [31:0] ip;
  } key_t;

  // Controller to datapath
  typedef struct packed {
    logic start;       // input transfer taken, latch the item
    logic scan_issue;  // read the next cache entry
    logic commit;      // table insert and result register load
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_scan;   // item must look the sender up in the cache
    logic issue_last;  // current read is the last filled entry
  } status_t;

endpackage

>>> design/arp_cache_responder.sv
// Top level of the ARP cache and responder: configuration registers and block wiring.
//
//  channel  direction  handshake          payload
//  cfg      in         psel/penable/pready local_mac (addr 0), local_ip (addr 8)
//  in       in         in_valid/in_stall  func, opcode, protocol_type, src_mac,
//                                         src_ip, target_ip
//  out      out        out_valid/out_stall send, out_opcode, dest_mac, out_src_mac,
//                                         out_src_ip, out_target_mac,
//                                         out_target_ip, table_action
//
// An item is taken only after the previous one commits; when the sender is looked up in
// the cache, the scan reads the filled entries (up to 16) one entry per cycle through
// the cache memory's single read port. Synchronous reset empties the cache (fill count
// to zero) and clears the configuration registers and the result valid flag.
// The result register holds a finished result under out_stall while the next item
// may already be taken; the commit waits only if that register is still full.
module arp_cache_responder (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [arpc_pkg::ADDR_W-1:0]   paddr,
  input  logic [arpc_pkg::DATA_W-1:0]   pwdata,
  output logic [arpc_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          func,
  input  logic [15:0]                   opcode,
  input  logic [15:0]                   protocol_type,
  input  logic [47:0]                   src_mac,
  input  logic [31:0]                   src_ip,
  input  logic [31:0]                   target_ip,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          send,
  output logic [1:0]                    out_opcode,
  output logic [47:0]                   dest_mac,
  output logic [47:0]                   out_src_mac,
  output logic [31:0]                   out_src_ip,
  output logic [47:0]                   out_target_mac,
  output logic [31:0]                   out_target_ip,
  output logic [1:0]                    table_action
);

  logic [47:0]        local_mac;
  logic [31:0]        local_ip;
  logic               cfg_wr;
  arpc_pkg::reg_idx_t reg_sel;
  arpc_pkg::cmd_t     cmd;
  arpc_pkg::status_t  status;

  // Register decode: 8-byte spacing
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = arpc_pkg::reg_idx_t'(paddr[3]);

  always_comb begin
    unique case (reg_sel)
      arpc_pkg::REG_LOCAL_MAC: prdata = {16'd0, local_mac};
      arpc_pkg::REG_LOCAL_IP:  prdata = {32'd0, local_ip};
      default:                 prdata = '0;
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      local_mac <= '0;
      local_ip  <= '0;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        arpc_pkg::REG_LOCAL_MAC: local_mac <= pwdata[47:0];
        arpc_pkg::REG_LOCAL_IP:  local_ip  <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  arpc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  arpc_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .local_mac      (local_mac),
    .local_ip       (local_ip),
    .func           (func),
    .opcode         (opcode),
    .protocol_type  (protocol_type),
    .src_mac        (src_mac),
    .src_ip         (src_ip),
    .target_ip      (target_ip),
    .send           (send),
    .out_opcode     (out_opcode),
    .dest_mac       (dest_mac),
    .out_src_mac    (out_src_mac),
    .out_src_ip     (out_src_ip),
    .out_target_mac (out_target_mac),
    .out_target_ip  (out_target_ip),
    .table_action   (table_action)
  );

endmodule

>>> design/arpc_ctrl.sv
// Sequencer for the ARP cache: accept, cache scan, commit and result handshake.
module arpc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  arpc_pkg::status_t status,
  output arpc_pkg::cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_COMMIT
  } state_t;

  state_t state;
  logic   out_free;

  // Result register is free when empty or being taken this cycle
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd.start      = (state == S_IDLE) && in_valid;
    cmd.scan_issue = (state == S_SCAN) && status.need_scan;
    cmd.commit     = (state == S_COMMIT) && out_free;
  end

  // State and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) state <= S_SCAN;
        end
        S_SCAN: begin
          if (!status.need_scan) begin
            state <= S_COMMIT;
          end else if (status.issue_last) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_COMMIT;
        end
        S_COMMIT: begin
          if (out_free) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A new item is never taken until the previous one is committed
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("arpc_ctrl: input taken while an item is in flight");

  // Commit never overwrites a result still waiting
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_valid || !out_stall))
    else $error("arpc_ctrl: commit over a pending result");

  // Scan reads never coincide with an accepted item or a commit
  a_scan_after_start: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_issue |-> !cmd.commit && !cmd.start)
    else $error("arpc_ctrl: scan overlaps start or commit");

endmodule

>>> design/arpc_dp.sv
// Datapath: item latch, cache memory with fill count, scan compare and result register.
module arpc_dp (
  input  logic                    clk,
  input  logic                    rst,
  input  arpc_pkg::cmd_t          cmd,
  output arpc_pkg::status_t       status,
  input  logic [47:0]             local_mac,
  input  logic [31:0]             local_ip,
  input  logic                    func,
  input  logic [15:0]             opcode,
  input  logic [15:0]             protocol_type,
  input  logic [47:0]             src_mac,
  input  logic [31:0]             src_ip,
  input  logic [31:0]             target_ip,
  output logic                    send,
  output logic [1:0]              out_opcode,
  output logic [47:0]             dest_mac,
  output logic [47:0]             out_src_mac,
  output logic [31:0]             out_src_ip,
  output logic [47:0]             out_target_mac,
  output logic [31:0]             out_target_ip,
  output logic [1:0]              table_action
);

  localparam int IDX_W = arpc_pkg::IDX_W;
  localparam int CNT_W = arpc_pkg::CNT_W;

  // Latched item
  logic        func_q;
  logic [15:0] opcode_q;
  logic [15:0] proto_q;
  logic [47:0] smac_q;
  logic [31:0] sip_q;
  logic [31:0] tip_q;

  // Cache store: entries below the fill count are valid
  arpc_pkg::key_t key_mem [arpc_pkg::TABLE_ENTRIES];
  logic [47:0]    mac_mem [arpc_pkg::TABLE_ENTRIES];
  logic [CNT_W-1:0] count;

  // Scan pipeline
  logic [IDX_W-1:0] rd_idx;
  arpc_pkg::key_t   rd_key;
  logic             cmp_valid;
  logic [IDX_W-1:0] cmp_idx;
  logic             hit;
  logic             match;

  // Decision
  logic             tip_local;
  logic             table_empty;
  logic             table_full;
  logic             table_op;
  logic             insert_wr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  arpc_pkg::action_t action;

  assign tip_local   = (tip_q == local_ip);
  assign table_empty = (count == '0);
  assign table_full  = (count == CNT_W'(arpc_pkg::TABLE_ENTRIES));
  assign table_op    = !func_q && (table_empty || tip_local);

  assign status.need_scan  = !func_q && !table_empty && tip_local;
  assign status.issue_last = (CNT_W'(rd_idx) == (count - CNT_W'(1)));

  // Compare stage sees the entry read in the previous cycle
  assign match = cmp_valid && (rd_key.proto == proto_q) && (rd_key.ip == sip_q);

  assign insert_wr = cmd.commit && table_op && !hit && !table_full;
  assign wr_en     = match || insert_wr;
  assign wr_addr   = match ? cmp_idx : count[IDX_W-1:0];

  always_comb begin
    if (!table_op) begin
      action = arpc_pkg::ACT_NONE;
    end else if (hit) begin
      action = arpc_pkg::ACT_UPDATE;
    end else if (table_full) begin
      action = arpc_pkg::ACT_FULL;
    end else begin
      action = arpc_pkg::ACT_INSERT;
    end
  end

  // Item latch on input transfer
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      func_q   <= func;
      opcode_q <= opcode;
      proto_q  <= protocol_type;
      smac_q   <= src_mac;
      sip_q    <= src_ip;
      tip_q    <= target_ip;
    end
  end

  // Cache memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= '{proto: proto_q, ip: sip_q};
      mac_mem[wr_addr] <= smac_q;
    end
    rd_key  <= key_mem[rd_idx];
    cmp_idx <= rd_idx;
  end

  // Scan control, hit flag and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      cmp_valid <= 1'b0;
      hit       <= 1'b0;
      rd_idx    <= '0;
    end else begin
      cmp_valid <= cmd.scan_issue;
      if (cmd.start) begin
        rd_idx <= '0;
        hit    <= 1'b0;
      end else begin
        if (cmd.scan_issue) rd_idx <= rd_idx + IDX_W'(1);
        if (match) hit <= 1'b1;
      end
      if (insert_wr) count <= count + CNT_W'(1);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      table_action <= action;
      if (func_q) begin
        send           <= 1'b1;
        out_opcode     <= arpc_pkg::OP_REQUEST;
        dest_mac       <= arpc_pkg::BCAST_MAC;
        out_src_mac    <= local_mac;
        out_src_ip     <= sip_q;
        out_target_mac <= arpc_pkg::BCAST_MAC;
        out_target_ip  <= tip_q;
      end else if (opcode_q == arpc_pkg::ARP_OP_REQUEST) begin
        send           <= 1'b1;
        out_opcode     <= arpc_pkg::OP_REPLY;
        dest_mac       <= smac_q;
        out_src_mac    <= local_mac;
        out_src_ip     <= local_ip;
        out_target_mac <= smac_q;
        out_target_ip  <= sip_q;
      end else begin
        send           <= 1'b0;
        out_opcode     <= arpc_pkg::OP_NONE;
        dest_mac       <= '0;
        out_src_mac    <= '0;
        out_src_ip     <= '0;
        out_target_mac <= '0;
        out_target_ip  <= '0;
      end
    end
  end

  // Fill count never passes the table size
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(arpc_pkg::TABLE_ENTRIES))
    else $error("arpc_dp: fill count out of range");

  // Scan reads only filled entries
  a_scan_filled: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_issue |-> (CNT_W'(rd_idx) < count))
    else $error("arpc_dp: scan beyond fill count");

  // An update write and an insert never collide
  a_one_write: assert property (@(posedge clk) disable iff (rst)
    !(match && insert_wr))
    else $error("arpc_dp: update and insert in the same cycle");

endmodule
